// ----- hw/rtl/zvc_pkg.sv -----
package zvc_pkg;

  // Stream widths: tdata carries value (63:0) and byte (71:64) on the slave
  // side, byte (7:0) and value (71:8) on the master side.
  localparam int DATA_W = 72;
  localparam int USER_W = 3;

  localparam int VAL_W = 64;
  localparam int BYTE_W = 8;
  localparam int CNT_W = 4;

  // Command codes carried in s_tuser[0].
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Result kinds carried in m_tuser.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  localparam logic [6:0] LOW7 = 7'h7f;
  localparam int GROUP = 7;

  // Byte limits per width.
  localparam logic [CNT_W-1:0] LIMIT_NARROW = 4'd5;
  localparam logic [CNT_W-1:0] LIMIT_WIDE = 4'd10;
  localparam logic [CNT_W-1:0] COUNT_MAX = 4'd9;

  typedef struct packed {
    logic enc_load;   // take a new encode word and emit its first byte
    logic enc_step;   // emit the next byte from the shift register
    logic dec_load;   // fold a decode byte into the accumulator
  } dp_cmd_t;

  typedef struct packed {
    logic enc_more_in;   // incoming value needs more than one byte
    logic enc_more_reg;  // shift register still holds more than one byte
    logic dec_done;      // the incoming decode byte ends the value
  } dp_sts_t;

endpackage

// ----- hw/rtl/zvc_ctrl.sv -----
module zvc_ctrl
  import zvc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    in_cmd,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ENC = 1'b1;

  logic state;
  logic state_next;
  logic m_tvalid_next;
  logic out_free;
  logic accept;
  logic emit;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept = s_tvalid && s_tready;

  assign cmd.enc_load = accept && (in_cmd == CMD_ENCODE);
  assign cmd.dec_load = accept && (in_cmd == CMD_DECODE);
  assign cmd.enc_step = (state == ST_ENC) && out_free;

  assign emit = cmd.enc_load || cmd.enc_step || (cmd.dec_load && sts.dec_done);

  always_comb begin
    if (emit) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.enc_load && sts.enc_more_in) begin
          state_next = ST_ENC;
        end
      end
      ST_ENC: begin
        if (cmd.enc_step && !sts.enc_more_reg) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

// ----- hw/rtl/zvc_datapath.sv -----
module zvc_datapath
  import zvc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic [VAL_W-1:0]  value_in,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic              wide,
  input  logic              signed_mode,
  output logic              kind,
  output logic [BYTE_W-1:0] byte_out,
  output logic [VAL_W-1:0]  value_out,
  output logic              last
);

  logic [VAL_W-1:0] zreg;
  logic [VAL_W-1:0] zin;
  logic [31:0]      n32;
  logic [31:0]      zz32;

  logic [VAL_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_inc;
  logic [6:0]       sh7;
  logic [5:0]       shamt;
  logic [VAL_W-1:0] acc_new;
  logic [VAL_W-1:0] dec_val;
  logic [31:0]      d32;
  logic             emit;

  // Zigzag map of the incoming value.
  assign n32 = value_in[31:0];
  assign zz32 = signed_mode ? ({n32[30:0], 1'b0} ^ {32{n32[31]}}) : n32;

  always_comb begin
    if (wide) begin
      zin = signed_mode ? ({value_in[VAL_W-2:0], 1'b0} ^ {VAL_W{value_in[VAL_W-1]}})
                        : value_in;
    end else begin
      zin = {32'b0, zz32};
    end
  end

  assign sts.enc_more_in = (zin[VAL_W-1:GROUP] != '0);
  assign sts.enc_more_reg = (zreg[VAL_W-1:GROUP] != '0);

  // Decode: byte count saturates at nine, payload lands at count * 7.
  assign count = (cnt > COUNT_MAX) ? COUNT_MAX : cnt;
  assign count_inc = count + 4'd1;
  assign sh7 = {count, 3'b000} - {3'b000, count};
  assign shamt = sh7[5:0];
  assign acc_new = acc | ({{(VAL_W-GROUP){1'b0}}, (byte_in[6:0] & LOW7)} << shamt);

  assign sts.dec_done = !byte_in[7] || (count_inc >= (wide ? LIMIT_WIDE : LIMIT_NARROW));

  assign d32 = signed_mode ? ({1'b0, acc_new[31:1]} ^ {32{acc_new[0]}}) : acc_new[31:0];

  always_comb begin
    if (wide) begin
      dec_val = signed_mode ? ({1'b0, acc_new[VAL_W-1:1]} ^ {VAL_W{acc_new[0]}}) : acc_new;
    end else begin
      dec_val = {{32{signed_mode & d32[31]}}, d32};
    end
  end

  assign emit = cmd.enc_load || cmd.enc_step || (cmd.dec_load && sts.dec_done);

  // Encode shift register; payload, no reset.
  always_ff @(posedge clk) begin
    if (cmd.enc_load) begin
      zreg <= zin >> GROUP;
    end else if (cmd.enc_step) begin
      zreg <= zreg >> GROUP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else if (cmd.dec_load) begin
      if (sts.dec_done) begin
        acc <= '0;
        cnt <= '0;
      end else begin
        acc <= acc_new;
        cnt <= count_inc;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (emit) begin
      if (cmd.enc_load) begin
        kind <= KIND_BYTE;
        byte_out <= {sts.enc_more_in, zin[6:0]};
        value_out <= '0;
        last <= !sts.enc_more_in;
      end else if (cmd.enc_step) begin
        kind <= KIND_BYTE;
        byte_out <= {sts.enc_more_reg, zreg[6:0]};
        value_out <= '0;
        last <= !sts.enc_more_reg;
      end else begin
        kind <= KIND_VALUE;
        byte_out <= '0;
        value_out <= dec_val;
        last <= 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/zigzag_varint_codec.sv -----
// Varint (LEB128) codec with optional zigzag mapping, 32- or 64-bit width.
// Slave channel: one word per item. s_tuser[0] selects encode (0) or decode
// (1), s_tuser[1] picks 64-bit width, s_tuser[2] turns on zigzag mapping.
// s_tdata carries the value to encode in bits 63:0 and the byte to decode
// in bits 71:64.
// Master channel: m_tuser says whether m_tdata holds an encoded byte (0, in
// bits 7:0) or a decoded value (1, in bits 71:8); m_tlast marks the final
// word caused by an input item.
// Encode: the first byte appears in the cycle after acceptance, then one byte
// per cycle while m_tready stays high, so an item gives 1 to 10 bytes; the single output register
// and the shift register, which drops seven bits per byte, set that pace.
// The input stays closed while bytes are left to send.
// Decode: one byte per cycle while the output is free; a value shows in the
// cycle after the byte ending it. A byte that does not end one gives no word.
// Backpressure: while m_tready is low the output word holds and s_tready
// drops once the output register is full.
// Reset (rst, synchronous) clears the decode accumulator and byte count and
// empties the output register.
module zigzag_varint_codec
  import zvc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // value_in[63:0], byte_in[71:64]
  input  logic [USER_W-1:0] s_tuser,   // cmd[0], wide[1], signed_mode[2]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // byte_out[7:0], value_out[71:8]
  output logic              m_tuser,   // kind[0]
  output logic              m_tlast
);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [BYTE_W-1:0] byte_out;
  logic [VAL_W-1:0]  value_out;

  // Sequencer: accepts items, paces the encode bytes, owns the output valid.
  zvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_cmd   (s_tuser[0]),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Zigzag mapping, byte shifter, decode accumulator and output register.
  zvc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .value_in    (s_tdata[VAL_W-1:0]),
    .byte_in     (s_tdata[VAL_W+BYTE_W-1:VAL_W]),
    .wide        (s_tuser[1]),
    .signed_mode (s_tuser[2]),
    .kind        (m_tuser),
    .byte_out    (byte_out),
    .value_out   (value_out),
    .last        (m_tlast)
  );

  assign m_tdata = {value_out, byte_out};

`ifndef SYNTHESIS
  // Input opens only when the output register can take a word.
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tready))
    else $error("input accepted with output register full");

  // An accepted encode puts a byte word out on the next cycle.
  a_enc_emits: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser[0] == CMD_ENCODE))
      |=> (m_tvalid && (m_tuser == KIND_BYTE)))
    else $error("encode produced no byte");

  // A decode byte without the continuation bit ends a value.
  a_dec_ends: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser[0] == CMD_DECODE) && !s_tdata[VAL_W+BYTE_W-1])
      |=> (m_tvalid && (m_tuser == KIND_VALUE) && m_tlast))
    else $error("terminating decode byte produced no value");

  // A decoded value is always the final word of its item.
  a_value_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_VALUE)) |-> m_tlast)
    else $error("value word without last");
`endif

endmodule
